@@ hdl/gbk_pkg.sv @@
// ----------------------------------------------------------------------------
// gbk_pkg
// Types and constants shared by the grid best-keypoint-per-cell block.
// ----------------------------------------------------------------------------
package gbk_pkg;

  // Field widths fixed by the item formats.
  localparam int COORD_W  = 16;
  localparam int SCORE_W  = 32;
  localparam int LEVEL_W  = 3;
  localparam int RINDEX_W = 12;
  localparam int COUNT_W  = 13;
  localparam int CSIZE_W  = 12;
  localparam int CGRID_W  = 7;
  localparam int CELLNO_W = 14;  // row * cells_across + column, up to 127 * 127 + 126
  localparam int LIMIT_W  = 17;  // wide enough to hold the largest cell storage depth
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // One stored cell: {occupied, level, score, y, x}.
  localparam int ENTRY_W = 1 + LEVEL_W + SCORE_W + 2 * COORD_W;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 88;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_ACROSS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_DOWN   = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the input item and start the dividers
    logic div_step;   // advance both dividers by one step
    logic calc;       // register the cell number and the range check
    logic upd;        // read-modify-write of the cell, build the result
    logic sweep;      // write one empty entry during a clearing pass
    logic clr_count;  // zero the occupied-cell count
    logic out_load;   // move the result into the output register
  } gbk_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic sweep_last;
    logic out_busy;
  } gbk_status_t;

endpackage

@@ hdl/grid_best_keypoint_per_cell_top.sv @@
// ----------------------------------------------------------------------------
// grid_best_keypoint_per_cell_top
// Keeps the highest-scoring keypoint in each cell of an image grid.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the in_ stream: in_tuser carries the operation (add,
// clear, read) and in_tdata the point and the cell number to read. Each item
// gives exactly one result transfer on the out_ stream with the store and
// range flags, the occupied-cell count and, for a read, the cell contents.
// The cfg_ port writes the cell size and grid size registers; it is always
// ready and is to be written only while the block is idle.
// Sequence. An add, a read or an unused code is accepted in the idle state;
// the two coordinate dividers, which retire four quotient bits a cycle, then
// run, the cell number and range check are registered, the cell is read and
// updated in the single read-modify-write of the cell store, and the result
// moves to the output register. The next item is taken in the cycle after the
// result has moved there. A clear walks the whole store, one entry a cycle.
// Reset. After rst_n the block runs a clearing pass over the whole store with
// in_tready low; configuration writes are taken during it.
// Stalls. A result waits in the output register while out_tready is low; the
// block works on the next item meanwhile and holds that one's result until
// the output register is free.
// ----------------------------------------------------------------------------
module grid_best_keypoint_per_cell_top
  import gbk_pkg::*;
#(
  parameter int MAX_CELLS = 4096,
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata from bit 0 up: x_coord[15:0], y_coord[31:16], point_score[63:32],
  // pyramid_level[66:64], read_index[78:67], zero[79].
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: operation[1:0].
  input  logic [OP_W-1:0]        in_tuser,
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata from bit 0 up: stored[0], out_of_grid[1], occupied_count[14:2],
  // cell_valid[15], cell_x[31:16], cell_y[47:32], cell_score[79:48],
  // cell_level[82:80], zero[87:83].
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Whole-pixel dividend width, rounded up to the four bits retired a cycle.
  localparam int DW = ((COORD_W - COORD_FRAC_BITS + 3) / 4) * 4;
  localparam int DIV_CYCLES = DW / 4;

  gbk_cmd_t    cmd;
  gbk_status_t status;

  assign cfg_ready = 1'b1;

  gbk_ctrl #(.DIV_CYCLES(DIV_CYCLES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .status    (status),
    .cmd       (cmd)
  );

  gbk_datapath #(
    .MAX_CELLS       (MAX_CELLS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_op      (in_tuser),
    .in_x       (in_tdata[15:0]),
    .in_y       (in_tdata[31:16]),
    .in_score   (in_tdata[63:32]),
    .in_level   (in_tdata[66:64]),
    .in_rindex  (in_tdata[78:67]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ hdl/gbk_ram.sv @@
// ----------------------------------------------------------------------------
// gbk_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gbk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/gbk_divider.sv @@
// ----------------------------------------------------------------------------
// gbk_divider
// Restoring divider for whole-pixel coordinates, four quotient bits a cycle while step is high.
// ----------------------------------------------------------------------------
module gbk_divider
  import gbk_pkg::*;
#(
  parameter int DW = 16
) (
  input  logic               clk,
  input  logic               start,
  input  logic               step,
  input  logic [DW-1:0]      dividend,
  input  logic [CSIZE_W-1:0] divisor,
  output logic [DW-1:0]      quotient
);

  logic [CSIZE_W-1:0] rem_r, rem_nxt;
  logic [DW-1:0]      quo_r, quo_nxt;

  // The dividend shifts out of the top of quo_r while quotient bits enter below.
  always_comb begin
    logic [CSIZE_W:0] r;
    logic [DW-1:0]    q;
    r = {1'b0, rem_r};
    q = quo_r;
    for (int i = 0; i < 4; i++) begin
      r = {r[CSIZE_W-1:0], q[DW-1]};
      q = {q[DW-2:0], 1'b0};
      if (r >= {1'b0, divisor}) begin
        r = r - {1'b0, divisor};
        q[0] = 1'b1;
      end
    end
    rem_nxt = r[CSIZE_W-1:0];
    quo_nxt = q;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;

endmodule

@@ hdl/gbk_datapath.sv @@
// ----------------------------------------------------------------------------
// gbk_datapath
// Configuration, dividers, cell store, occupied count and output register.
// ----------------------------------------------------------------------------
module gbk_datapath
  import gbk_pkg::*;
#(
  parameter int MAX_CELLS = 4096,
  parameter int COORD_FRAC_BITS = 4,
  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1,
  localparam int DW = ((COORD_W - COORD_FRAC_BITS + 3) / 4) * 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gbk_cmd_t               cmd,
  output gbk_status_t            status,
  input  logic [OP_W-1:0]        in_op,
  input  logic [COORD_W-1:0]     in_x,
  input  logic [COORD_W-1:0]     in_y,
  input  logic [SCORE_W-1:0]     in_score,
  input  logic [LEVEL_W-1:0]     in_level,
  input  logic [RINDEX_W-1:0]    in_rindex,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [CSIZE_W-1:0] cell_w_r, cell_h_r;
  logic [CGRID_W-1:0] across_r, down_r;

  logic [OP_W-1:0]     op_r;
  logic [COORD_W-1:0]  x_r, y_r;
  logic [SCORE_W-1:0]  score_r;
  logic [LEVEL_W-1:0]  level_r;
  logic [RINDEX_W-1:0] rindex_r;

  logic [DW-1:0] qx, qy;

  logic [AW-1:0] addr_r, addr_nxt;
  logic          inrange_r, inrange_nxt;
  logic [AW-1:0] sweep_addr_r;
  logic          sweep_last;

  logic [COUNT_W-1:0] count_r;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic               occ;
  logic [SCORE_W-1:0] old_score;
  logic               replace;
  logic               add_write;

  logic               res_stored_r, res_oog_r, res_valid_r;
  logic [COORD_W-1:0] res_x_r, res_y_r;
  logic [SCORE_W-1:0] res_score_r;
  logic [LEVEL_W-1:0] res_level_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_w_r <= CSIZE_W'(32);
      cell_h_r <= CSIZE_W'(32);
      across_r <= CGRID_W'(20);
      down_r   <= CGRID_W'(15);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CELL_WIDTH:   cell_w_r <= cfg_data;
        CFG_CELL_HEIGHT:  cell_h_r <= cfg_data;
        CFG_CELLS_ACROSS: across_r <= cfg_data[CGRID_W-1:0];
        CFG_CELLS_DOWN:   down_r   <= cfg_data[CGRID_W-1:0];
        default: ;
      endcase
    end
  end

  // Input item capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      x_r      <= in_x;
      y_r      <= in_y;
      score_r  <= in_score;
      level_r  <= in_level;
      rindex_r <= in_rindex;
    end
  end

  gbk_divider #(.DW(DW)) u_div_x (
    .clk      (clk),
    .start    (cmd.load),
    .step     (cmd.div_step),
    .dividend (DW'(in_x >> COORD_FRAC_BITS)),
    .divisor  (cell_w_r),
    .quotient (qx)
  );

  gbk_divider #(.DW(DW)) u_div_y (
    .clk      (clk),
    .start    (cmd.load),
    .step     (cmd.div_step),
    .dividend (DW'(in_y >> COORD_FRAC_BITS)),
    .divisor  (cell_h_r),
    .quotient (qy)
  );

  // Cell number and range check.
  always_comb begin
    logic                col_ok;
    logic                row_ok;
    logic [CELLNO_W-1:0] cellno;
    logic [CELLNO_W-1:0] limit;
    logic                add_ok;
    logic                rd_ok;
    col_ok = (cell_w_r != '0) && (qx < DW'(across_r));
    row_ok = (cell_h_r != '0) && (qy < DW'(down_r));
    cellno = CELLNO_W'(qy[CGRID_W-1:0]) * CELLNO_W'(across_r) + CELLNO_W'(qx[CGRID_W-1:0]);
    limit  = CELLNO_W'(across_r) * CELLNO_W'(down_r);
    add_ok = col_ok && row_ok && (LIMIT_W'(cellno) < LIMIT_W'(MAX_CELLS));
    rd_ok  = (CELLNO_W'(rindex_r) < limit) && (LIMIT_W'(rindex_r) < LIMIT_W'(MAX_CELLS));
    if (op_r == OP_READ) begin
      addr_nxt    = AW'(rindex_r);
      inrange_nxt = rd_ok;
    end else begin
      addr_nxt    = AW'(cellno);
      inrange_nxt = add_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      addr_r    <= addr_nxt;
      inrange_r <= inrange_nxt;
    end
  end

  // Clearing pass address.
  assign sweep_last = (sweep_addr_r == AW'(MAX_CELLS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_addr_r <= '0;
    end else if (cmd.sweep) begin
      sweep_addr_r <= sweep_last ? '0 : sweep_addr_r + AW'(1);
    end
  end

  // Cell store update.
  assign occ       = ram_rdata[ENTRY_W-1];
  assign old_score = ram_rdata[2*COORD_W +: SCORE_W];
  assign replace   = !occ || (old_score < score_r);
  assign add_write = cmd.upd && (op_r == OP_ADD) && inrange_r && replace;

  always_comb begin
    if (cmd.sweep) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = add_write;
      ram_waddr = addr_r;
      ram_wdata = {1'b1, level_r, score_r, y_r, x_r};
    end
  end

  gbk_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CELLS)) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_count) begin
      count_r <= '0;
    end else if (add_write && !occ) begin
      count_r <= count_r + COUNT_W'(1);
    end
  end

  // Result assembly.
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      res_stored_r <= (op_r == OP_ADD) && inrange_r && replace;
      res_oog_r    <= ((op_r == OP_ADD) || (op_r == OP_READ)) && !inrange_r;
      if ((op_r == OP_READ) && inrange_r && occ) begin
        res_valid_r <= 1'b1;
        res_x_r     <= ram_rdata[0 +: COORD_W];
        res_y_r     <= ram_rdata[COORD_W +: COORD_W];
        res_score_r <= old_score;
        res_level_r <= ram_rdata[2*COORD_W+SCORE_W +: LEVEL_W];
      end else begin
        res_valid_r <= 1'b0;
        res_x_r     <= '0;
        res_y_r     <= '0;
        res_score_r <= '0;
        res_level_r <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {5'b0, res_level_r, res_score_r, res_y_r, res_x_r, res_valid_r,
                     count_r, res_oog_r, res_stored_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign status.sweep_last = sweep_last;
  assign status.out_busy   = out_valid_r && !out_tready;

endmodule

@@ hdl/gbk_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbk_ctrl
// Sequencer for one item at a time: divide, check, read, update, deliver; a clear sweeps the store instead.
// ----------------------------------------------------------------------------
module gbk_ctrl
  import gbk_pkg::*;
#(
  parameter int DIV_CYCLES = 4,
  localparam int DCW = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [OP_W-1:0] in_op,
  input  gbk_status_t     status,
  output gbk_cmd_t        cmd
);

  localparam logic [2:0] S_SWEEP_RST = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_DIV       = 3'd2;
  localparam logic [2:0] S_CALC      = 3'd3;
  localparam logic [2:0] S_RD        = 3'd4;
  localparam logic [2:0] S_UPD       = 3'd5;
  localparam logic [2:0] S_OUT       = 3'd6;
  localparam logic [2:0] S_SWEEP_CLR = 3'd7;

  logic [2:0]     state_r, state_nxt;
  logic [DCW-1:0] div_cnt_r, div_cnt_nxt;
  logic           accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    case (state_r)
      S_SWEEP_RST: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load    = 1'b1;
          div_cnt_nxt = '0;
          if (in_op == OP_CLEAR) begin
            cmd.clr_count = 1'b1;
            state_nxt     = S_SWEEP_CLR;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + DCW'(1);
        if (div_cnt_r == DCW'(DIV_CYCLES - 1)) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SWEEP_CLR: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_nxt = S_UPD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_SWEEP_RST;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

endmodule
